@@ src/cipf_pkg.sv @@
// Shared types, constants and helpers for the case-insensitive pattern finder.
// No dependencies; every other file imports this package.
package cipf_pkg;

    localparam int CHAR_W    = 8;
    localparam int PAT_BYTES = 8;
    localparam int POS_W     = 32;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 64;
    localparam int RAW_LEN_W = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PATTERN_CHARS  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_PATTERN_LENGTH = t_cfg_idx'(1);

    typedef logic [PAT_BYTES-1:0][CHAR_W-1:0] t_pat;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] match_start;
        logic [CNT_W-1:0] match_number;
    } t_out_item;

    // Map upper-case ASCII letters onto lower case; every other byte is kept.
    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

@@ src/cipf_cfg.sv @@
// Configuration registers: pattern bytes and pattern length.
// Presents the case-folded pattern and the clamped length. Depends on cipf_pkg.
module cipf_cfg import cipf_pkg::*; #(
    parameter int MAX_PATTERN = 8,
    parameter int LEN_W       = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  t_cfg_idx             i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_pat                 o_pat,
    output logic [LEN_W-1:0]     o_len
);

    localparam int CMP_W = (LEN_W > RAW_LEN_W) ? LEN_W : RAW_LEN_W;

    logic [CFG_DAT_W-1:0] r_pattern_chars;
    logic [RAW_LEN_W-1:0] r_pattern_length;
    logic [CMP_W-1:0]     len_nz;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_chars  <= '0;
            r_pattern_length <= RAW_LEN_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PATTERN_CHARS:  r_pattern_chars  <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[RAW_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int p = 0; p < PAT_BYTES; p++) begin
            o_pat[p] = fold_case(r_pattern_chars[p*CHAR_W +: CHAR_W]);
        end
    end

    // Zero length behaves as one; anything past the window limit is clipped.
    always_comb begin
        len_nz = (r_pattern_length == '0) ? CMP_W'(1) : CMP_W'(r_pattern_length);
        if (len_nz > CMP_W'(MAX_PATTERN)) begin
            o_len = LEN_W'(MAX_PATTERN);
        end else begin
            o_len = LEN_W'(len_nz);
        end
    end

endmodule

@@ src/cipf_core.sv @@
// Text state and match logic: character window, position, seen count,
// overlap hold-off and match count. Depends on cipf_pkg.
module cipf_core import cipf_pkg::*; #(
    parameter int MAX_PATTERN = 8,
    parameter int LEN_W       = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  t_in_item         i_item,
    input  t_pat             i_pat,
    input  logic [LEN_W-1:0] i_len,
    output logic             o_hit,
    output t_out_item        o_res
);

    localparam int WIN   = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam int OVL_W = (MAX_PATTERN > 2) ? $clog2(MAX_PATTERN) : 1;

    logic [WIN-1:0][CHAR_W-1:0] r_win;
    logic [POS_W-1:0]           r_text_pos;
    logic [LEN_W-1:0]           r_seen;
    logic [OVL_W-1:0]           r_ovl;
    logic [CNT_W-1:0]           r_found;

    logic [CHAR_W-1:0] c;
    logic [LEN_W-1:0]  seen_next;
    logic [POS_W-1:0]  len_m1;
    logic [CNT_W-1:0]  found_next;
    logic              hit;

    // Pick a pattern byte by position; positions past the register read as zero.
    function automatic logic [CHAR_W-1:0] pat_at(input int idx, input t_pat pat);
        logic [CHAR_W-1:0] r;
        r = '0;
        for (int p = 0; p < PAT_BYTES; p++) begin
            if (idx == p) begin
                r = pat[p];
            end
        end
        return r;
    endfunction

    assign c      = fold_case(i_item.text_char);
    assign len_m1 = POS_W'(i_len) - POS_W'(1);

    always_comb begin
        seen_next = (r_seen < LEN_W'(MAX_PATTERN)) ? r_seen + LEN_W'(1) : r_seen;
        hit = (seen_next >= i_len) && (r_ovl == '0)
              && (c == pat_at(int'(i_len) - 1, i_pat));
        // Window entry j holds the byte j+1 places back; compare it in parallel.
        for (int j = 0; j < WIN; j++) begin
            if ((j + 1 < int'(i_len)) && (r_win[j] != pat_at(int'(i_len) - 2 - j, i_pat))) begin
                hit = 1'b0;
            end
        end
    end

    assign found_next = (r_found != '1) ? r_found + CNT_W'(1) : r_found;

    assign o_hit              = hit;
    assign o_res.match_start  = (r_text_pos >= len_m1) ? r_text_pos - len_m1 : '0;
    assign o_res.match_number = found_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_text_pos <= '0;
            r_seen     <= '0;
            r_ovl      <= '0;
            r_found    <= '0;
        end else if (i_advance) begin
            if (i_item.end_of_text) begin
                r_win      <= '0;
                r_text_pos <= '0;
                r_seen     <= '0;
                r_ovl      <= '0;
                r_found    <= '0;
            end else begin
                for (int j = WIN - 1; j > 0; j--) begin
                    r_win[j] <= r_win[j-1];
                end
                r_win[0] <= c;
                if (r_text_pos != '1) begin
                    r_text_pos <= r_text_pos + POS_W'(1);
                end
                r_seen <= seen_next;
                if (hit) begin
                    r_found <= found_next;
                    r_ovl   <= OVL_W'(i_len - LEN_W'(1));
                end else if (r_ovl != '0) begin
                    r_ovl <= r_ovl - OVL_W'(1);
                end
            end
        end
    end

endmodule

@@ src/cipf_out_reg.sv @@
// Result register: holds one finished beat until the consumer takes it.
// Depends on cipf_pkg.
module cipf_out_reg import cipf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  logic      i_hit,
    input  t_out_item i_res,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    output logic      o_blocked
);

    logic      r_valid;
    t_out_item r_data;

    // Full and not drained this cycle: the compare stage must hold.
    assign o_blocked   = r_valid && i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_hit;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_hit) begin
            r_data <= i_res;
        end
    end

endmodule

@@ src/case_insensitive_pattern_finder_top.sv @@
// Top level of the case-insensitive pattern finder: input register,
// configuration, match core and result register. Depends on cipf_pkg.
//
//  Channel  Direction  Handshake                 Beat
//  in       sink       i_in_valid / o_in_stall   t_in_item (text_char, end_of_text)
//  out      source     o_out_valid / i_out_stall t_out_item (match_start, match_number)
//  cfg      sink       i_cfg_valid / o_cfg_ready index + 64-bit data
//
// One text byte per cycle unless o_in_stall holds the input register. A byte is
// matched against the window while it sits in the input register, and its result
// (if any) is loaded into the result register as the byte leaves the input register.
// Reset (synchronous, active low) clears the text state and loads pattern
// length one. A stall on the result side holds the input register only while
// the result register is full; o_cfg_ready is always high.
module case_insensitive_pattern_finder_top import cipf_pkg::*; #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  t_cfg_idx             i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic             r_in_valid;
    t_in_item         r_in_data;
    t_pat             pat;
    logic [LEN_W-1:0] len;
    logic             blocked;
    logic             advance;
    logic             hit;
    t_out_item        res;

    assign advance    = r_in_valid && !blocked;
    assign o_in_stall = r_in_valid && blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    cipf_cfg #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pat       (pat),
        .o_len       (len)
    );

    cipf_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_data),
        .i_pat     (pat),
        .i_len     (len),
        .o_hit     (hit),
        .o_res     (res)
    );

    cipf_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_hit       (hit),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_blocked   (blocked)
    );

endmodule
